// ----- hw/rtl/ghfd_pkg.sv -----
package ghfd_pkg;

  // Grid geometry and sample format
  localparam int MAX_SIDE    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int ID_W        = 15;
  localparam int STORE_DEPTH = 2 ** ID_W;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int STRIDE_W    = 2 * SIDE_W;
  localparam int DIV_CNT_W   = $clog2(ID_W + 1);

  // Accumulators: diagonal terms b + f - 2c, cross terms four-corner sum
  localparam int ACC_W  = SAMPLE_BITS + 2;
  localparam int HD_W   = ACC_W + 2;
  localparam int HC_W   = ACC_W;
  localparam int NUM_ACC = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [SIDE_W-1:0]    SIZE_RESET = SIDE_W'(MAX_SIDE);

  // Accumulator select masks
  localparam logic [NUM_ACC-1:0] ACC_XX   = 6'b000001;
  localparam logic [NUM_ACC-1:0] ACC_YY   = 6'b000010;
  localparam logic [NUM_ACC-1:0] ACC_ZZ   = 6'b000100;
  localparam logic [NUM_ACC-1:0] ACC_XY   = 6'b001000;
  localparam logic [NUM_ACC-1:0] ACC_XZ   = 6'b010000;
  localparam logic [NUM_ACC-1:0] ACC_YZ   = 6'b100000;
  localparam logic [NUM_ACC-1:0] ACC_DIAG = ACC_XX | ACC_YY | ACC_ZZ;

  // Program layout
  localparam int NUM_READS = 19;
  localparam int RD_IDX_W  = $clog2(NUM_READS);
  localparam int PC_W      = 5;
  localparam logic [PC_W-1:0] ST_IDLE     = PC_W'(0);
  localparam logic [PC_W-1:0] ST_DIV_X    = PC_W'(1);
  localparam logic [PC_W-1:0] ST_WAIT_X   = PC_W'(2);
  localparam logic [PC_W-1:0] ST_DIV_Y    = PC_W'(3);
  localparam logic [PC_W-1:0] ST_WAIT_Y   = PC_W'(4);
  localparam logic [PC_W-1:0] ST_SPLIT    = PC_W'(5);
  localparam logic [PC_W-1:0] ST_RD0      = PC_W'(6);
  localparam logic [PC_W-1:0] ST_ACC_LAST = PC_W'(6 + NUM_READS);
  localparam logic [PC_W-1:0] ST_FINISH   = PC_W'(7 + NUM_READS);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_DIV_X,
    OP_DIV_Y,
    OP_SPLIT,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_BACK,
    OFF_FRONT
  } off_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_IF_DIV_BUSY,
    C_IF_NO_QUERY,
    C_IF_OOR,
    C_WHILE_OUT_FULL
  } cond_e;

  typedef struct packed {
    off_e                ox;
    off_e                oy;
    off_e                oz;
    logic [NUM_ACC-1:0]  acc_en;
    logic                acc_neg;
    logic                acc_dbl;
  } rd_t;

  typedef struct packed {
    op_e                 op;
    logic                rd_en;
    off_e                ox;
    off_e                oy;
    off_e                oz;
    logic [NUM_ACC-1:0]  acc_en;
    logic                acc_neg;
    logic                acc_dbl;
    cond_e               cond;
    logic [PC_W-1:0]     target;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic query_acc;
    logic oor;
    logic out_full;
  } stat_t;

  function automatic logic [SIDE_W-1:0] eff_size(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (s == '0) begin
      r = SIDE_W'(1);
    end else if (s > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic rd_t mk_rd(input off_e ox, input off_e oy, input off_e oz,
                                input logic [NUM_ACC-1:0] en, input logic neg,
                                input logic dbl);
    rd_t r;
    r.ox      = ox;
    r.oy      = oy;
    r.oz      = oz;
    r.acc_en  = en;
    r.acc_neg = neg;
    r.acc_dbl = dbl;
    return r;
  endfunction

  // Neighbor visit order and the weight each sample carries
  function automatic rd_t rd_tab(input logic [RD_IDX_W-1:0] i);
    rd_t r;
    unique case (i)
      5'd0:  r = mk_rd(OFF_ZERO,  OFF_ZERO,  OFF_ZERO,  ACC_DIAG, 1'b1, 1'b1);
      5'd1:  r = mk_rd(OFF_BACK,  OFF_ZERO,  OFF_ZERO,  ACC_XX,   1'b0, 1'b0);
      5'd2:  r = mk_rd(OFF_FRONT, OFF_ZERO,  OFF_ZERO,  ACC_XX,   1'b0, 1'b0);
      5'd3:  r = mk_rd(OFF_ZERO,  OFF_BACK,  OFF_ZERO,  ACC_YY,   1'b0, 1'b0);
      5'd4:  r = mk_rd(OFF_ZERO,  OFF_FRONT, OFF_ZERO,  ACC_YY,   1'b0, 1'b0);
      5'd5:  r = mk_rd(OFF_ZERO,  OFF_ZERO,  OFF_BACK,  ACC_ZZ,   1'b0, 1'b0);
      5'd6:  r = mk_rd(OFF_ZERO,  OFF_ZERO,  OFF_FRONT, ACC_ZZ,   1'b0, 1'b0);
      5'd7:  r = mk_rd(OFF_FRONT, OFF_FRONT, OFF_ZERO,  ACC_XY,   1'b0, 1'b0);
      5'd8:  r = mk_rd(OFF_FRONT, OFF_BACK,  OFF_ZERO,  ACC_XY,   1'b1, 1'b0);
      5'd9:  r = mk_rd(OFF_BACK,  OFF_FRONT, OFF_ZERO,  ACC_XY,   1'b1, 1'b0);
      5'd10: r = mk_rd(OFF_BACK,  OFF_BACK,  OFF_ZERO,  ACC_XY,   1'b0, 1'b0);
      5'd11: r = mk_rd(OFF_FRONT, OFF_ZERO,  OFF_FRONT, ACC_XZ,   1'b0, 1'b0);
      5'd12: r = mk_rd(OFF_FRONT, OFF_ZERO,  OFF_BACK,  ACC_XZ,   1'b1, 1'b0);
      5'd13: r = mk_rd(OFF_BACK,  OFF_ZERO,  OFF_FRONT, ACC_XZ,   1'b1, 1'b0);
      5'd14: r = mk_rd(OFF_BACK,  OFF_ZERO,  OFF_BACK,  ACC_XZ,   1'b0, 1'b0);
      5'd15: r = mk_rd(OFF_ZERO,  OFF_FRONT, OFF_FRONT, ACC_YZ,   1'b0, 1'b0);
      5'd16: r = mk_rd(OFF_ZERO,  OFF_FRONT, OFF_BACK,  ACC_YZ,   1'b1, 1'b0);
      5'd17: r = mk_rd(OFF_ZERO,  OFF_BACK,  OFF_FRONT, ACC_YZ,   1'b1, 1'b0);
      5'd18: r = mk_rd(OFF_ZERO,  OFF_BACK,  OFF_BACK,  ACC_YZ,   1'b0, 1'b0);
      default: r = mk_rd(OFF_ZERO, OFF_ZERO, OFF_ZERO, '0, 1'b0, 1'b0);
    endcase
    return r;
  endfunction

  // Control store: read step k issues neighbor k-ST_RD0 and folds in the previous one
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    rd_t   r;
    w         = '0;
    w.op      = OP_NOP;
    w.ox      = OFF_ZERO;
    w.oy      = OFF_ZERO;
    w.oz      = OFF_ZERO;
    w.cond    = C_NEXT;
    w.target  = ST_IDLE;
    if (pc == ST_IDLE) begin
      w.op     = OP_IDLE;
      w.cond   = C_IF_NO_QUERY;
      w.target = ST_IDLE;
    end else if (pc == ST_DIV_X) begin
      w.op = OP_DIV_X;
    end else if (pc == ST_WAIT_X) begin
      w.cond   = C_IF_DIV_BUSY;
      w.target = ST_WAIT_X;
    end else if (pc == ST_DIV_Y) begin
      w.op = OP_DIV_Y;
    end else if (pc == ST_WAIT_Y) begin
      w.cond   = C_IF_DIV_BUSY;
      w.target = ST_WAIT_Y;
    end else if (pc == ST_SPLIT) begin
      w.op     = OP_SPLIT;
      w.cond   = C_IF_OOR;
      w.target = ST_FINISH;
    end else if (pc >= ST_RD0 && pc <= ST_ACC_LAST) begin
      if (pc < ST_ACC_LAST) begin
        r       = rd_tab(RD_IDX_W'(pc - ST_RD0));
        w.rd_en = 1'b1;
        w.ox    = r.ox;
        w.oy    = r.oy;
        w.oz    = r.oz;
      end
      if (pc > ST_RD0) begin
        r         = rd_tab(RD_IDX_W'(pc - ST_RD0 - PC_W'(1)));
        w.acc_en  = r.acc_en;
        w.acc_neg = r.acc_neg;
        w.acc_dbl = r.acc_dbl;
      end
    end else if (pc == ST_FINISH) begin
      w.op     = OP_FINISH;
      w.cond   = C_WHILE_OUT_FULL;
      w.target = ST_IDLE;
    end else begin
      w.cond   = C_GOTO;
      w.target = ST_IDLE;
    end
    return w;
  endfunction

endpackage

// ----- hw/rtl/grid_hessian_finite_difference_top.sv -----
// Sample writes: accepted one per cycle while no query is in progress, no result.
// Queries: one at a time, no input is taken until the result is loaded; an off-grid id
// skips the neighbor reads. The work is two 15-step serial divisions that split the id
// and 19 neighbor reads through the single port of the sample store.
// Reset clears the sequencer, handshakes and sizes (32 each); the sample store is not
// cleared, a sample reads back only after it has been written.
module grid_hessian_finite_difference_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [ghfd_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [ghfd_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     in_kind_i,
  input  logic [ghfd_pkg::ID_W-1:0]                in_point_id_i,
  input  logic signed [ghfd_pkg::SAMPLE_BITS-1:0]  in_sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [ghfd_pkg::ID_W-1:0]                out_point_echo_o,
  output logic signed [ghfd_pkg::HD_W-1:0]         out_hxx_o,
  output logic signed [ghfd_pkg::HD_W-1:0]         out_hyy_o,
  output logic signed [ghfd_pkg::HD_W-1:0]         out_hzz_o,
  output logic signed [ghfd_pkg::HC_W-1:0]         out_hxy_o,
  output logic signed [ghfd_pkg::HC_W-1:0]         out_hxz_o,
  output logic signed [ghfd_pkg::HC_W-1:0]         out_hyz_o,
  output logic                                     out_out_of_range_o
);

  localparam int IW = ghfd_pkg::ID_W;
  localparam int SW = ghfd_pkg::SIDE_W;
  localparam int AW = ghfd_pkg::ACC_W;

  ghfd_pkg::ctrl_t ctrl;
  ghfd_pkg::stat_t stat;

  logic [SW-1:0] size_x_q, size_y_q, size_z_q;
  logic [SW-1:0] sx, sy, sz;

  logic [IW-1:0]                  pid_q;
  logic [SW-1:0]                  x_q, y_q, z_q;
  logic [ghfd_pkg::STRIDE_W-1:0]  sxy_q;
  logic                           oor_q;
  logic signed [AW-1:0]           acc_q [ghfd_pkg::NUM_ACC];

  logic                           out_valid_q;
  logic [IW-1:0]                  echo_q;
  logic signed [AW-1:0]           res_q [ghfd_pkg::NUM_ACC];
  logic                           res_oor_q;

  logic                           in_acc;
  logic                           div_start;
  logic [IW-1:0]                  div_dividend;
  logic [SW-1:0]                  div_divisor;
  logic                           div_busy;
  logic [IW-1:0]                  div_quot;
  logic [SW-1:0]                  div_rem;
  logic                           oor_now;
  logic                           out_full;

  logic                           st_we;
  logic [IW-1:0]                  st_addr;
  logic signed [ghfd_pkg::SAMPLE_BITS-1:0] st_rdata;

  logic [IW-1:0]                  tx, ty, tz, rd_addr;
  logic                           x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok, z_lo_ok, z_hi_ok;
  logic signed [AW-1:0]           smp, term;

  assign sx = ghfd_pkg::eff_size(size_x_q);
  assign sy = ghfd_pkg::eff_size(size_y_q);
  assign sz = ghfd_pkg::eff_size(size_z_q);

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= ghfd_pkg::SIZE_RESET;
      size_y_q <= ghfd_pkg::SIZE_RESET;
      size_z_q <= ghfd_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ghfd_pkg::CFG_SIZE_X) size_x_q <= SW'(cfg_data_i);
      if (cfg_index_i == ghfd_pkg::CFG_SIZE_Y) size_y_q <= SW'(cfg_data_i);
      if (cfg_index_i == ghfd_pkg::CFG_SIZE_Z) size_z_q <= SW'(cfg_data_i);
    end
  end

  // Sequencer
  assign in_ready_o = (ctrl.op == ghfd_pkg::OP_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_full   = out_valid_q && !out_ready_i;
  assign oor_now    = div_quot >= IW'(sz);

  assign stat.div_busy  = div_busy;
  assign stat.query_acc = in_acc && in_kind_i;
  assign stat.oor       = oor_now;
  assign stat.out_full  = out_full;

  ghfd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Id split: x = id mod sx, then y and z from the quotient
  assign div_start    = (ctrl.op == ghfd_pkg::OP_DIV_X) || (ctrl.op == ghfd_pkg::OP_DIV_Y);
  assign div_dividend = (ctrl.op == ghfd_pkg::OP_DIV_X) ? pid_q : div_quot;
  assign div_divisor  = (ctrl.op == ghfd_pkg::OP_DIV_X) ? sx : sy;

  ghfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Neighbor address: center id plus clamped offsets times the axis strides
  assign x_lo_ok = x_q != '0;
  assign y_lo_ok = y_q != '0;
  assign z_lo_ok = z_q != '0;
  assign x_hi_ok = ({1'b0, x_q} + 1'b1) < {1'b0, sx};
  assign y_hi_ok = ({1'b0, y_q} + 1'b1) < {1'b0, sy};
  assign z_hi_ok = ({1'b0, z_q} + 1'b1) < {1'b0, sz};

  always_comb begin
    tx = '0;
    ty = '0;
    tz = '0;
    if (ctrl.ox == ghfd_pkg::OFF_BACK && x_lo_ok)  tx = '1;
    if (ctrl.ox == ghfd_pkg::OFF_FRONT && x_hi_ok) tx = IW'(1);
    if (ctrl.oy == ghfd_pkg::OFF_BACK && y_lo_ok)  ty = IW'(0) - IW'(sx);
    if (ctrl.oy == ghfd_pkg::OFF_FRONT && y_hi_ok) ty = IW'(sx);
    if (ctrl.oz == ghfd_pkg::OFF_BACK && z_lo_ok)  tz = IW'(0) - IW'(sxy_q);
    if (ctrl.oz == ghfd_pkg::OFF_FRONT && z_hi_ok) tz = IW'(sxy_q);
  end

  assign rd_addr = pid_q + tx + ty + tz;

  assign st_we   = in_acc && !in_kind_i;
  assign st_addr = (ctrl.op == ghfd_pkg::OP_IDLE) ? in_point_id_i : rd_addr;

  ghfd_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (in_sample_i),
    .rdata_o (st_rdata)
  );

  // Weighted accumulation of the sample read in the previous step
  assign smp  = AW'(st_rdata);
  assign term = ctrl.acc_dbl ? (smp <<< 1) : smp;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pid_q <= in_point_id_i;
    end
    if (ctrl.op == ghfd_pkg::OP_DIV_Y) begin
      x_q <= div_rem;
    end
    if (ctrl.op == ghfd_pkg::OP_SPLIT) begin
      y_q   <= div_rem;
      z_q   <= div_quot[SW-1:0];
      oor_q <= oor_now;
      sxy_q <= ghfd_pkg::STRIDE_W'(sx) * ghfd_pkg::STRIDE_W'(sy);
    end
    for (int k = 0; k < ghfd_pkg::NUM_ACC; k++) begin
      if (ctrl.op == ghfd_pkg::OP_DIV_X) begin
        acc_q[k] <= '0;
      end else if (ctrl.acc_en[k]) begin
        acc_q[k] <= ctrl.acc_neg ? acc_q[k] - term : acc_q[k] + term;
      end
    end
  end

  // Output register: load on finish, hold until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == ghfd_pkg::OP_FINISH && !out_full) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == ghfd_pkg::OP_FINISH && !out_full) begin
      echo_q    <= pid_q;
      res_oor_q <= oor_q;
      for (int k = 0; k < ghfd_pkg::NUM_ACC; k++) begin
        res_q[k] <= oor_q ? '0 : acc_q[k];
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_point_echo_o   = echo_q;
  assign out_hxx_o          = {res_q[0], 2'b00};
  assign out_hyy_o          = {res_q[1], 2'b00};
  assign out_hzz_o          = {res_q[2], 2'b00};
  assign out_hxy_o          = res_q[3];
  assign out_hxz_o          = res_q[4];
  assign out_hyz_o          = res_q[5];
  assign out_out_of_range_o = res_oor_q;

endmodule

// ----- hw/rtl/ghfd_store.sv -----
module ghfd_store (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [ghfd_pkg::ID_W-1:0]             addr_i,
  input  logic signed [ghfd_pkg::SAMPLE_BITS-1:0] wdata_i,
  output logic signed [ghfd_pkg::SAMPLE_BITS-1:0] rdata_o
);

  logic signed [ghfd_pkg::SAMPLE_BITS-1:0] mem [ghfd_pkg::STORE_DEPTH];
  logic signed [ghfd_pkg::SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ghfd_div.sv -----
module ghfd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ghfd_pkg::ID_W-1:0]     dividend_i,
  input  logic [ghfd_pkg::SIDE_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [ghfd_pkg::ID_W-1:0]     quot_o,
  output logic [ghfd_pkg::SIDE_W-1:0]   rem_o
);

  logic                            busy_q;
  logic [ghfd_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [ghfd_pkg::ID_W-1:0]       quo_q;
  logic [ghfd_pkg::SIDE_W-1:0]     rem_q;
  logic [ghfd_pkg::SIDE_W-1:0]     div_q;
  logic [ghfd_pkg::SIDE_W:0]       trial;
  logic [ghfd_pkg::SIDE_W:0]       diff;
  logic                            ge;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[ghfd_pkg::ID_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ghfd_pkg::DIV_CNT_W'(ghfd_pkg::ID_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ghfd_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[ghfd_pkg::SIDE_W-1:0] : trial[ghfd_pkg::SIDE_W-1:0];
      quo_q <= {quo_q[ghfd_pkg::ID_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/ghfd_seq.sv -----
module ghfd_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghfd_pkg::stat_t   stat_i,
  output ghfd_pkg::ctrl_t   ctrl_o
);

  logic [ghfd_pkg::PC_W-1:0] pc_q;
  logic [ghfd_pkg::PC_W-1:0] pc_d;
  logic [ghfd_pkg::PC_W-1:0] pc_inc;
  ghfd_pkg::ctrl_t           ctrl;

  assign ctrl   = ghfd_pkg::ucode(pc_q);
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    unique case (ctrl.cond)
      ghfd_pkg::C_NEXT:           pc_d = pc_inc;
      ghfd_pkg::C_GOTO:           pc_d = ctrl.target;
      ghfd_pkg::C_IF_DIV_BUSY:    pc_d = stat_i.div_busy ? ctrl.target : pc_inc;
      ghfd_pkg::C_IF_NO_QUERY:    pc_d = stat_i.query_acc ? pc_inc : ctrl.target;
      ghfd_pkg::C_IF_OOR:         pc_d = stat_i.oor ? ctrl.target : pc_inc;
      ghfd_pkg::C_WHILE_OUT_FULL: pc_d = stat_i.out_full ? pc_q : ctrl.target;
      default:                    pc_d = ghfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ghfd_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic [ghfd_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic                                    kind;
    logic [ghfd_pkg::ID_W-1:0]               point_id;
    logic signed [ghfd_pkg::SAMPLE_BITS-1:0] value;
    logic                                    hold;
  } grid_op_t;

  typedef struct packed {
    logic [ghfd_pkg::ID_W-1:0]        echo;
    logic signed [ghfd_pkg::HD_W-1:0] hxx;
    logic signed [ghfd_pkg::HD_W-1:0] hyy;
    logic signed [ghfd_pkg::HD_W-1:0] hzz;
    logic signed [ghfd_pkg::HC_W-1:0] hxy;
    logic signed [ghfd_pkg::HC_W-1:0] hxz;
    logic signed [ghfd_pkg::HC_W-1:0] hyz;
    logic                             oor;
  } hessian_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ghfd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ghfd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic in_kind_i = KIND_WRITE;
  logic [ghfd_pkg::ID_W-1:0] in_point_id_i = '0;
  logic signed [ghfd_pkg::SAMPLE_BITS-1:0] in_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ghfd_pkg::ID_W-1:0] out_point_echo_o;
  logic signed [ghfd_pkg::HD_W-1:0] out_hxx_o, out_hyy_o, out_hzz_o;
  logic signed [ghfd_pkg::HC_W-1:0] out_hxy_o, out_hxz_o, out_hyz_o;
  logic out_out_of_range_o;

  grid_hessian_finite_difference_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_kind_i         (in_kind_i),
    .in_point_id_i     (in_point_id_i),
    .in_sample_i       (in_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_point_echo_o  (out_point_echo_o),
    .out_hxx_o         (out_hxx_o),
    .out_hyy_o         (out_hyy_o),
    .out_hzz_o         (out_hzz_o),
    .out_hxy_o         (out_hxy_o),
    .out_hxz_o         (out_hxz_o),
    .out_hyz_o         (out_hyz_o),
    .out_out_of_range_o(out_out_of_range_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: sample volume and register shadow as seen at transaction time
  logic signed [ghfd_pkg::SAMPLE_BITS-1:0] volume [ghfd_pkg::STORE_DEPTH];
  logic [ghfd_pkg::CFG_DATA_W-1:0] reg_side [3] = '{6'd32, 6'd32, 6'd32};
  hessian_t hessian_due [$];

  // Stimulus side: pending transactions and the ids they leave written
  grid_op_t pending [$];
  bit loaded [ghfd_pkg::STORE_DEPTH];
  int gx = 32, gy = 32, gz = 32, gen_total = 32768;
  int pushed = 0;

  int queries_sent = 0;
  int results_got = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_tick = 0;
  int cycles = 0;
  sink_mode_e sink_mode = SINK_OPEN;

  function automatic int side_eff(input logic [ghfd_pkg::CFG_DATA_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > ghfd_pkg::MAX_SIDE) return ghfd_pkg::MAX_SIDE;
    return int'(raw);
  endfunction

  function automatic int clamp_axis(input int c, input int n);
    if (c < 0) return 0;
    if (c >= n) return n - 1;
    return c;
  endfunction

  function automatic int sample_at(input int x, input int y, input int z);
    int sx, sy;
    sx = side_eff(reg_side[0]);
    sy = side_eff(reg_side[1]);
    return int'(volume[x + sx * (y + sy * z)]);
  endfunction

  function automatic hessian_t hessian_at(input logic [ghfd_pkg::ID_W-1:0] pid);
    hessian_t h;
    int sx, sy, sz, x, y, z, xl, xh, yl, yh, zl, zh, c;
    sx = side_eff(reg_side[0]);
    sy = side_eff(reg_side[1]);
    sz = side_eff(reg_side[2]);
    h = '0;
    h.echo = pid;
    if (int'(pid) >= sx * sy * sz) begin
      h.oor = 1'b1;
      return h;
    end
    x = int'(pid) % sx;
    y = (int'(pid) / sx) % sy;
    z = int'(pid) / (sx * sy);
    xl = clamp_axis(x - 1, sx);
    xh = clamp_axis(x + 1, sx);
    yl = clamp_axis(y - 1, sy);
    yh = clamp_axis(y + 1, sy);
    zl = clamp_axis(z - 1, sz);
    zh = clamp_axis(z + 1, sz);
    c = sample_at(x, y, z);
    h.hxx = ghfd_pkg::HD_W'(4 * (sample_at(xl, y, z) + sample_at(xh, y, z) - 2 * c));
    h.hyy = ghfd_pkg::HD_W'(4 * (sample_at(x, yl, z) + sample_at(x, yh, z) - 2 * c));
    h.hzz = ghfd_pkg::HD_W'(4 * (sample_at(x, y, zl) + sample_at(x, y, zh) - 2 * c));
    h.hxy = ghfd_pkg::HC_W'(sample_at(xh, yh, z) - sample_at(xh, yl, z)
                          - sample_at(xl, yh, z) + sample_at(xl, yl, z));
    h.hxz = ghfd_pkg::HC_W'(sample_at(xh, y, zh) - sample_at(xh, y, zl)
                          - sample_at(xl, y, zh) + sample_at(xl, y, zl));
    h.hyz = ghfd_pkg::HC_W'(sample_at(x, yh, zh) - sample_at(x, yh, zl)
                          - sample_at(x, yl, zh) + sample_at(x, yl, zl));
    return h;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: bursts from the pending queue, predictions taken at acceptance
  always @(posedge clk_i or negedge rst_ni) begin : feed
    grid_op_t nxt;
    logic took;
    int sent_now;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      queries_sent <= 0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      took = in_valid_i && in_ready_o;
      sent_now = queries_sent;
      if (took) begin
        if (in_kind_i == KIND_QUERY) begin
          hessian_due.push_back(hessian_at(in_point_id_i));
          sent_now++;
        end else begin
          volume[in_point_id_i] = in_sample_i;
        end
        queries_sent <= sent_now;
      end
      if (!in_valid_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0 && (!pending[0].hold || sent_now == results_got)) begin
          nxt = pending.pop_front();
          in_valid_i    <= 1'b1;
          in_kind_i     <= nxt.kind;
          in_point_id_i <= nxt.point_id;
          in_sample_i   <= nxt.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : sink
    hessian_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      results_got <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_got <= results_got + 1;
        if (hessian_due.size() == 0) begin
          $display("%0t: unexpected result, point %0d", $time, out_point_echo_o);
          errors++;
        end else begin
          want = hessian_due.pop_front();
          check_field("point_echo", want.echo, out_point_echo_o);
          check_field("hxx", want.hxx, out_hxx_o);
          check_field("hyy", want.hyy, out_hyy_o);
          check_field("hzz", want.hzz, out_hzz_o);
          check_field("hxy", want.hxy, out_hxy_o);
          check_field("hxz", want.hxz, out_hxz_o);
          check_field("hyz", want.hyz, out_hyz_o);
          check_field("out_of_range", want.oor, out_out_of_range_o);
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) sink_mode = sink_mode_e'($urandom_range(0, 2));
      case (sink_mode)
        SINK_OPEN: out_ready_i <= 1'b1;
        SINK_COIN: out_ready_i <= 1'($urandom_range(0, 1));
        default:   out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_op(input logic kind, input int pid, input logic signed [15:0] v);
    grid_op_t op;
    op.kind = kind;
    op.point_id = ghfd_pkg::ID_W'(pid);
    op.value = v;
    // hold off now and then until every outstanding query has answered
    op.hold = (pushed % 97 == 40);
    pending.push_back(op);
    pushed++;
  endtask

  task automatic push_write(input int pid, input logic signed [15:0] v);
    loaded[pid] = 1'b1;
    push_op(KIND_WRITE, pid, v);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write every neighbor the query will read that holds no sample yet
  task automatic plan_query(input int pid);
    int x, y, z, dx, dy, dz, nid;
    if (pid < gen_total) begin
      x = pid % gx;
      y = (pid / gx) % gy;
      z = pid / (gx * gy);
      for (dx = -1; dx <= 1; dx++) begin
        for (dy = -1; dy <= 1; dy++) begin
          for (dz = -1; dz <= 1; dz++) begin
            if (dx == 0 || dy == 0 || dz == 0) begin
              nid = clamp_axis(x + dx, gx)
                  + gx * (clamp_axis(y + dy, gy) + gy * clamp_axis(z + dz, gz));
              if (!loaded[nid]) push_write(nid, pick_sample());
            end
          end
        end
      end
    end
    push_op(KIND_QUERY, pid, 16'($urandom));
  endtask

  task automatic wait_idle(input int settle);
    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || queries_sent != results_got);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ghfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ghfd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx != CFG_NONE) reg_side[idx] = data;
  endtask

  task automatic set_sizes(input int x, input int y, input int z);
    write_reg(ghfd_pkg::CFG_SIZE_X, ghfd_pkg::CFG_DATA_W'(x));
    write_reg(ghfd_pkg::CFG_SIZE_Y, ghfd_pkg::CFG_DATA_W'(y));
    write_reg(ghfd_pkg::CFG_SIZE_Z, ghfd_pkg::CFG_DATA_W'(z));
    // unmapped index: must leave the sizes alone
    write_reg(CFG_NONE, ghfd_pkg::CFG_DATA_W'($urandom_range(0, 63)));
    gx = side_eff(ghfd_pkg::CFG_DATA_W'(x));
    gy = side_eff(ghfd_pkg::CFG_DATA_W'(y));
    gz = side_eff(ghfd_pkg::CFG_DATA_W'(z));
    gen_total = gx * gy * gz;
  endtask

  task automatic run_phase(input int x, input int y, input int z, input int count);
    int start, roll;
    set_sizes(x, y, z);
    start = pushed;
    while (pushed - start < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        plan_query($urandom_range(0, gen_total - 1));
      end else if (roll < 55) begin
        if (gen_total < ghfd_pkg::STORE_DEPTH) begin
          plan_query($urandom_range(ghfd_pkg::STORE_DEPTH - 1, gen_total));
        end else begin
          plan_query($urandom_range(0, gen_total - 1));
        end
      end else if (roll < 85) begin
        push_write($urandom_range(0, gen_total - 1), pick_sample());
      end else begin
        push_write($urandom_range(0, ghfd_pkg::STORE_DEPTH - 1), pick_sample());
      end
    end
    wait_idle(8);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Line of three: largest and smallest second difference along x
    set_sizes(3, 1, 1);
    push_write(0, 32767);
    push_write(1, -32768);
    push_write(2, 32767);
    plan_query(1);
    push_write(0, -32768);
    push_write(1, 32767);
    push_write(2, -32768);
    plan_query(1);
    wait_idle(8);

    // Square of four: extreme mixed term, corner clamping, off-grid ids
    set_sizes(2, 2, 1);
    push_write(0, 32767);
    push_write(1, -32768);
    push_write(2, -32768);
    push_write(3, 32767);
    plan_query(0);
    plan_query(3);
    push_write(0, -32768);
    plan_query(0);
    plan_query(4);
    plan_query(ghfd_pkg::STORE_DEPTH - 1);
    push_write(ghfd_pkg::STORE_DEPTH - 1, 0);
    wait_idle(8);

    run_phase(32, 32, 32, 100);
    run_phase(1, 1, 1, 100);
    run_phase(0, 0, 0, 60);
    run_phase(63, 33, 40, 100);
    run_phase(4, 4, 4, 100);
    run_phase(32, 1, 1, 100);
    run_phase(1, 32, 1, 100);
    run_phase(1, 1, 32, 100);
    run_phase(2, 3, 5, 100);
    run_phase(32, 32, 1, 100);
    while (pushed < 1170) begin
      if ($urandom_range(0, 1) == 0) begin
        run_phase($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5), 60);
      end else begin
        run_phase($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63), 60);
      end
    end

    wait_idle(80);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
